[src/fdu_pkg.sv]
`default_nettype none

package fdu_pkg;

    localparam int ROUTE_SLOTS = 16;
    localparam int PORT_COUNT = 4;

    localparam int RIDX_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
    localparam int IIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int RCNT_W = $clog2(ROUTE_SLOTS + 1);
    localparam int ICNT_W = $clog2(PORT_COUNT + 1);
    localparam int SCAN_W = (RCNT_W > ICNT_W) ? RCNT_W : ICNT_W;

    localparam logic [1:0] CMD_WR_ROUTE = 2'd0;
    localparam logic [1:0] CMD_WR_IFACE = 2'd1;
    localparam logic [1:0] CMD_CLASSIFY = 2'd2;

    localparam logic [2:0] ACT_FORWARD = 3'd0;
    localparam logic [2:0] ACT_NO_ROUTE = 3'd1;
    localparam logic [2:0] ACT_TTL_EXCEEDED = 3'd2;
    localparam logic [2:0] ACT_ECHO_REPLY = 3'd3;
    localparam logic [2:0] ACT_PORT_UNREACH = 3'd4;
    localparam logic [2:0] ACT_DROP = 3'd5;
    localparam logic [2:0] ACT_WRITE_ACK = 3'd6;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
    localparam logic [7:0] ICMP_UNREACH = 8'd3;
    localparam logic [7:0] ICMP_CODE_PORT = 8'd3;
    localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] REPLY_TTL = 8'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IF_SCAN,
        ST_IF_PORT,
        ST_IF_WAIT,
        ST_RT_SCAN,
        ST_DF_SCAN
    } state_t;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] netmask;
        logic [31:0] gateway;
        logic [1:0]  egress;
    } route_entry_t;

    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] idx;
        logic              used;
        route_entry_t      entry;
    } route_wr_t;

    typedef struct packed {
        logic         used;
        route_entry_t entry;
    } route_rd_t;

    typedef struct packed {
        logic              en;
        logic [IIDX_W-1:0] idx;
        logic              used;
        logic [31:0]       addr;
    } iface_wr_t;

    typedef struct packed {
        logic        used;
        logic [31:0] addr;
    } iface_rd_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] next_hop;
        logic [1:0]  out_port;
        logic [7:0]  new_ttl;
        logic [31:0] reply_src;
        logic [7:0]  reply_type;
        logic [7:0]  reply_code;
    } result_t;

endpackage

`default_nettype wire

[src/fdu_route_mem.sv]
`default_nettype none

module fdu_route_mem (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire fdu_pkg::route_wr_t        wr,
    input  wire logic [fdu_pkg::RIDX_W-1:0] raddr,
    output fdu_pkg::route_rd_t             rd
);

    fdu_pkg::route_entry_t mem [fdu_pkg::ROUTE_SLOTS];
    logic [fdu_pkg::ROUTE_SLOTS-1:0] used_reg;
    fdu_pkg::route_entry_t entry_reg;
    logic used_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.entry;
        end
        entry_reg <= mem[raddr];
    end

    // Valid marks live in flops so that reset clears them at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            used_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                used_reg[wr.idx] <= wr.used;
            end
            used_rd_reg <= used_reg[raddr];
        end
    end

    assign rd.used = used_rd_reg;
    assign rd.entry = entry_reg;

endmodule

`default_nettype wire

[src/fdu_iface_mem.sv]
`default_nettype none

module fdu_iface_mem (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire fdu_pkg::iface_wr_t         wr,
    input  wire logic [fdu_pkg::IIDX_W-1:0] raddr,
    output fdu_pkg::iface_rd_t              rd
);

    logic [31:0] mem [fdu_pkg::PORT_COUNT];
    logic [fdu_pkg::PORT_COUNT-1:0] used_reg;
    logic [31:0] addr_reg;
    logic used_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.addr;
        end
        addr_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            used_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                used_reg[wr.idx] <= wr.used;
            end
            used_rd_reg <= used_reg[raddr];
        end
    end

    assign rd.used = used_rd_reg;
    assign rd.addr = addr_reg;

endmodule

`default_nettype wire

[src/fdu_ctrl.sv]
`default_nettype none

module fdu_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [1:0]                  cmd,
    input  wire logic [3:0]                  slot,
    input  wire logic [31:0]                 address,
    input  wire logic [31:0]                 route_mask,
    input  wire logic [31:0]                 gateway,
    input  wire logic [1:0]                  port,
    input  wire logic                        entry_valid,
    input  wire logic [7:0]                  ttl,
    input  wire logic [7:0]                  protocol,
    input  wire logic [7:0]                  icmp_type_in,
    input  wire logic [7:0]                  icmp_code_in,
    output logic                             busy,
    output fdu_pkg::route_wr_t               route_wr,
    output logic [fdu_pkg::RIDX_W-1:0]       route_raddr,
    input  wire fdu_pkg::route_rd_t          route_rd,
    output fdu_pkg::iface_wr_t               iface_wr,
    output logic [fdu_pkg::IIDX_W-1:0]       iface_raddr,
    input  wire fdu_pkg::iface_rd_t          iface_rd,
    output logic                             done,
    output fdu_pkg::result_t                 result
);

    fdu_pkg::state_t state_reg, state_next;
    logic [fdu_pkg::SCAN_W-1:0] cnt_reg;
    logic pend_reg;
    logic done_reg;
    fdu_pkg::result_t res_reg, res_next;
    logic res_load;

    logic [31:0] dst_reg;
    logic [7:0]  ttl_reg;
    logic [7:0]  proto_reg;
    logic [7:0]  itype_reg;
    logic [7:0]  icode_reg;
    logic [1:0]  port_reg;

    logic accept;
    logic [31:0] slot_ext;
    logic [31:0] port_ext;
    logic port_ok;
    logic [fdu_pkg::SCAN_W-1:0] scan_limit;
    logic issue;
    logic scan_end;
    logic if_hit;
    logic rt_hit;
    logic df_hit;
    logic [31:0] rt_hop;

    assign busy = (state_reg != fdu_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign slot_ext = 32'(slot);
    assign port_ext = 32'(port_reg);
    assign port_ok = port_ext < 32'(fdu_pkg::PORT_COUNT);

    always_comb
    begin
        route_wr.en = accept && (cmd == fdu_pkg::CMD_WR_ROUTE)
                      && (slot_ext < 32'(fdu_pkg::ROUTE_SLOTS));
        route_wr.idx = slot_ext[fdu_pkg::RIDX_W-1:0];
        route_wr.used = entry_valid;
        route_wr.entry.prefix = address;
        route_wr.entry.netmask = route_mask;
        route_wr.entry.gateway = gateway;
        route_wr.entry.egress = port;
        iface_wr.en = accept && (cmd == fdu_pkg::CMD_WR_IFACE)
                      && (slot_ext < 32'(fdu_pkg::PORT_COUNT));
        iface_wr.idx = slot_ext[fdu_pkg::IIDX_W-1:0];
        iface_wr.used = entry_valid;
        iface_wr.addr = address;
    end

    // One read is issued per cycle; its data is checked in the next cycle
    // while pend_reg marks it present.
    always_comb
    begin
        scan_limit = (state_reg == fdu_pkg::ST_IF_SCAN)
                     ? fdu_pkg::SCAN_W'(fdu_pkg::PORT_COUNT)
                     : fdu_pkg::SCAN_W'(fdu_pkg::ROUTE_SLOTS);
        issue = cnt_reg < scan_limit;
        scan_end = !pend_reg && (cnt_reg == scan_limit);
        route_raddr = cnt_reg[fdu_pkg::RIDX_W-1:0];
        if (state_reg == fdu_pkg::ST_IF_PORT)
        begin
            iface_raddr = port_ext[fdu_pkg::IIDX_W-1:0];
        end
        else
        begin
            iface_raddr = cnt_reg[fdu_pkg::IIDX_W-1:0];
        end
        if_hit = pend_reg && iface_rd.used && (iface_rd.addr == dst_reg);
        rt_hit = pend_reg && route_rd.used && (route_rd.entry.netmask != 32'd0)
                 && (route_rd.entry.prefix == (dst_reg & route_rd.entry.netmask));
        df_hit = pend_reg && route_rd.used && (route_rd.entry.netmask == 32'd0)
                 && (route_rd.entry.prefix == 32'd0);
        rt_hop = (route_rd.entry.gateway != 32'd0) ? route_rd.entry.gateway : dst_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fdu_pkg::ST_IDLE:
            begin
                if (accept && (cmd == fdu_pkg::CMD_CLASSIFY))
                begin
                    state_next = fdu_pkg::ST_IF_SCAN;
                end
            end
            fdu_pkg::ST_IF_SCAN:
            begin
                if (if_hit)
                begin
                    state_next = fdu_pkg::ST_IDLE;
                end
                else if (scan_end)
                begin
                    state_next = (ttl_reg <= 8'd1) ? fdu_pkg::ST_IF_PORT
                                                   : fdu_pkg::ST_RT_SCAN;
                end
            end
            fdu_pkg::ST_IF_PORT:
            begin
                state_next = fdu_pkg::ST_IF_WAIT;
            end
            fdu_pkg::ST_IF_WAIT:
            begin
                state_next = fdu_pkg::ST_IDLE;
            end
            fdu_pkg::ST_RT_SCAN:
            begin
                if (rt_hit)
                begin
                    state_next = (rt_hop != 32'd0) ? fdu_pkg::ST_IDLE
                                                   : fdu_pkg::ST_DF_SCAN;
                end
                else if (scan_end)
                begin
                    state_next = fdu_pkg::ST_DF_SCAN;
                end
            end
            fdu_pkg::ST_DF_SCAN:
            begin
                if (df_hit || scan_end)
                begin
                    state_next = fdu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fdu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_load = 1'b0;
        res_next.action = fdu_pkg::ACT_DROP;
        res_next.next_hop = 32'd0;
        res_next.out_port = port_reg;
        res_next.new_ttl = 8'd0;
        res_next.reply_src = 32'd0;
        res_next.reply_type = 8'd0;
        res_next.reply_code = 8'd0;
        case (state_reg)
            fdu_pkg::ST_IDLE:
            begin
                if (accept && (cmd != fdu_pkg::CMD_CLASSIFY))
                begin
                    res_load = 1'b1;
                    res_next.out_port = 2'd0;
                    if ((cmd == fdu_pkg::CMD_WR_ROUTE) || (cmd == fdu_pkg::CMD_WR_IFACE))
                    begin
                        res_next.action = fdu_pkg::ACT_WRITE_ACK;
                    end
                end
            end
            fdu_pkg::ST_IF_SCAN:
            begin
                if (if_hit)
                begin
                    res_load = 1'b1;
                    if (proto_reg == fdu_pkg::PROTO_ICMP)
                    begin
                        if ((itype_reg == fdu_pkg::ICMP_ECHO_REQUEST) && (icode_reg == 8'd0))
                        begin
                            res_next.action = fdu_pkg::ACT_ECHO_REPLY;
                            res_next.new_ttl = fdu_pkg::REPLY_TTL;
                            res_next.reply_src = dst_reg;
                            res_next.reply_type = fdu_pkg::ICMP_ECHO_REPLY;
                        end
                    end
                    else if ((proto_reg == fdu_pkg::PROTO_UDP)
                             || (proto_reg == fdu_pkg::PROTO_TCP))
                    begin
                        res_next.action = fdu_pkg::ACT_PORT_UNREACH;
                        res_next.new_ttl = fdu_pkg::REPLY_TTL;
                        res_next.reply_src = dst_reg;
                        res_next.reply_type = fdu_pkg::ICMP_UNREACH;
                        res_next.reply_code = fdu_pkg::ICMP_CODE_PORT;
                    end
                end
            end
            fdu_pkg::ST_IF_WAIT:
            begin
                res_load = 1'b1;
                res_next.action = fdu_pkg::ACT_TTL_EXCEEDED;
                res_next.new_ttl = fdu_pkg::REPLY_TTL;
                res_next.reply_src = port_ok ? iface_rd.addr : 32'd0;
                res_next.reply_type = fdu_pkg::ICMP_TIME_EXCEEDED;
            end
            fdu_pkg::ST_RT_SCAN:
            begin
                if (rt_hit && (rt_hop != 32'd0))
                begin
                    res_load = 1'b1;
                    res_next.action = fdu_pkg::ACT_FORWARD;
                    res_next.next_hop = rt_hop;
                    res_next.out_port = route_rd.entry.egress;
                    res_next.new_ttl = ttl_reg - 8'd1;
                end
            end
            fdu_pkg::ST_DF_SCAN:
            begin
                // A default entry is taken even when its gateway is zero.
                if (df_hit)
                begin
                    res_load = 1'b1;
                    res_next.action = fdu_pkg::ACT_FORWARD;
                    res_next.next_hop = route_rd.entry.gateway;
                    res_next.out_port = route_rd.entry.egress;
                    res_next.new_ttl = ttl_reg - 8'd1;
                end
                else if (scan_end)
                begin
                    res_load = 1'b1;
                    res_next.action = fdu_pkg::ACT_NO_ROUTE;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdu_pkg::ST_IDLE;
            cnt_reg <= '0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= res_load;
            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
                pend_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= issue ? (cnt_reg + fdu_pkg::SCAN_W'(1)) : cnt_reg;
                pend_reg <= issue;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if (accept && (cmd == fdu_pkg::CMD_CLASSIFY))
        begin
            dst_reg <= address;
            ttl_reg <= ttl;
            proto_reg <= protocol;
            itype_reg <= icmp_type_in;
            icode_reg <= icmp_code_in;
            port_reg <= port;
        end
    end

    assign done = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

[src/ipv4_forward_decision_unit.sv]
`default_nettype none

// IPv4 forwarding decision with a 16-slot route table and a 4-slot interface
// address table, both held in synchronous memories.
// A word is taken at a rising edge where start is high and busy is low; cmd
// selects a route write, an interface write or a packet classification.
// Every word gives exactly one result, shown for one cycle while done is high.
// Writes and unused commands answer in the cycle after they are taken, and a
// new word may be taken in that same cycle.
// A classification scans the interface table; unless a local address matches,
// it then reads the arrival interface address when the TTL is 1 or less, or
// else scans the route table and then the route table again for a default
// entry, one memory read per cycle. Each table has a single read port.
// Busy stays high for the whole scan and falls in the cycle the result shows.
// Reset clears all valid marks; table contents stay undefined until written.
// The result has no back pressure: the receiver must take it when done is high.
// The packet source address does not enter the decision.

module ipv4_forward_decision_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [3:0]  slot,
    input  wire logic [31:0] address,
    input  wire logic [31:0] route_mask,
    input  wire logic [31:0] gateway,
    input  wire logic [31:0] src_addr,
    input  wire logic [1:0]  port,
    input  wire logic        entry_valid,
    input  wire logic [7:0]  ttl,
    input  wire logic [7:0]  protocol,
    input  wire logic [7:0]  icmp_type_in,
    input  wire logic [7:0]  icmp_code_in,
    output logic             done,
    output logic [2:0]       action,
    output logic [31:0]      next_hop,
    output logic [1:0]       out_port,
    output logic [7:0]       new_ttl,
    output logic [31:0]      reply_src,
    output logic [7:0]       icmp_type_out,
    output logic [7:0]       icmp_code_out
);

    fdu_pkg::route_wr_t route_wr;
    fdu_pkg::route_rd_t route_rd;
    logic [fdu_pkg::RIDX_W-1:0] route_raddr;
    fdu_pkg::iface_wr_t iface_wr;
    fdu_pkg::iface_rd_t iface_rd;
    logic [fdu_pkg::IIDX_W-1:0] iface_raddr;
    fdu_pkg::result_t result;

    fdu_route_mem u_route_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (route_wr),
        .raddr (route_raddr),
        .rd    (route_rd)
    );

    fdu_iface_mem u_iface_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (iface_wr),
        .raddr (iface_raddr),
        .rd    (iface_rd)
    );

    fdu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .slot         (slot),
        .address      (address),
        .route_mask   (route_mask),
        .gateway      (gateway),
        .port         (port),
        .entry_valid  (entry_valid),
        .ttl          (ttl),
        .protocol     (protocol),
        .icmp_type_in (icmp_type_in),
        .icmp_code_in (icmp_code_in),
        .busy         (busy),
        .route_wr     (route_wr),
        .route_raddr  (route_raddr),
        .route_rd     (route_rd),
        .iface_wr     (iface_wr),
        .iface_raddr  (iface_raddr),
        .iface_rd     (iface_rd),
        .done         (done),
        .result       (result)
    );

    assign action = result.action;
    assign next_hop = result.next_hop;
    assign out_port = result.out_port;
    assign new_ttl = result.new_ttl;
    assign reply_src = result.reply_src;
    assign icmp_type_out = result.reply_type;
    assign icmp_code_out = result.reply_code;

    a_write_answers_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd != fdu_pkg::CMD_CLASSIFY)) |=> done)
        else $error("write or unused command gave no result in the next cycle");

    a_classify_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == fdu_pkg::CMD_CLASSIFY)) |=> (busy && !done))
        else $error("classification did not start a scan");

    a_hop_only_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (action != fdu_pkg::ACT_FORWARD)) |-> (next_hop == 32'd0))
        else $error("next hop set on a result that does not forward");

    a_reply_ttl: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((action == fdu_pkg::ACT_ECHO_REPLY)
                  || (action == fdu_pkg::ACT_PORT_UNREACH)
                  || (action == fdu_pkg::ACT_TTL_EXCEEDED)))
        |-> (new_ttl == fdu_pkg::REPLY_TTL))
        else $error("generated reply without the reply TTL");

endmodule

`default_nettype wire

[sim/ipv4_forward_decision_unit_test.sv]
`timescale 1ns / 1ps

module ipv4_forward_decision_unit_test;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 60;
    localparam int RANDOM_WORDS = 375;

    typedef struct {
        logic [1:0]  cmd;
        logic [3:0]  slot;
        logic [31:0] address;
        logic [31:0] route_mask;
        logic [31:0] gateway;
        logic [31:0] src_addr;
        logic [1:0]  port;
        logic        entry_valid;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [7:0]  pkt_type;
        logic [7:0]  pkt_code;
        int          gap;
        bit          drain;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  cmd = '0;
    logic [3:0]  slot = '0;
    logic [31:0] address = '0;
    logic [31:0] route_mask = '0;
    logic [31:0] gateway = '0;
    logic [31:0] src_addr = '0;
    logic [1:0]  port = '0;
    logic        entry_valid = 1'b0;
    logic [7:0]  ttl = '0;
    logic [7:0]  protocol = '0;
    logic [7:0]  icmp_type_in = '0;
    logic [7:0]  icmp_code_in = '0;
    logic        busy;
    logic        done;
    logic [2:0]  action;
    logic [31:0] next_hop;
    logic [1:0]  out_port;
    logic [7:0]  new_ttl;
    logic [31:0] reply_src;
    logic [7:0]  icmp_type_out;
    logic [7:0]  icmp_code_out;

    ipv4_forward_decision_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .slot          (slot),
        .address       (address),
        .route_mask    (route_mask),
        .gateway       (gateway),
        .src_addr      (src_addr),
        .port          (port),
        .entry_valid   (entry_valid),
        .ttl           (ttl),
        .protocol      (protocol),
        .icmp_type_in  (icmp_type_in),
        .icmp_code_in  (icmp_code_in),
        .done          (done),
        .action        (action),
        .next_hop      (next_hop),
        .out_port      (out_port),
        .new_ttl       (new_ttl),
        .reply_src     (reply_src),
        .icmp_type_out (icmp_type_out),
        .icmp_code_out (icmp_code_out)
    );

    always #10 clk = ~clk;

    // Predictor copy of the tables.
    logic [31:0] rt_prefix [fdu_pkg::ROUTE_SLOTS];
    logic [31:0] rt_mask [fdu_pkg::ROUTE_SLOTS];
    logic [31:0] rt_gateway [fdu_pkg::ROUTE_SLOTS];
    logic [1:0]  rt_egress [fdu_pkg::ROUTE_SLOTS];
    bit          rt_valid [fdu_pkg::ROUTE_SLOTS];
    logic [31:0] if_addr [fdu_pkg::PORT_COUNT];
    bit          if_valid [fdu_pkg::PORT_COUNT];

    // What the generator has written, used only to aim destinations and interface addresses.
    logic [31:0] gen_prefix [fdu_pkg::ROUTE_SLOTS];
    logic [31:0] gen_mask [fdu_pkg::ROUTE_SLOTS];
    bit          gen_set [fdu_pkg::ROUTE_SLOTS];
    logic [31:0] gen_iface [fdu_pkg::PORT_COUNT];

    word_t            words_to_send [$];
    fdu_pkg::result_t decisions_due [$];
    word_t            cur;
    int               wait_cnt = 0;
    int               stall = 0;
    int               burst_left = 0;
    bit               hold_next = 0;
    int               words_sent = 0;
    int               results_seen = 0;
    int               mismatches = 0;
    int               action_count [8];

    function automatic fdu_pkg::result_t decide_forwarding(input word_t w);
        fdu_pkg::result_t r;
        logic [31:0]      hop;
        logic [1:0]       eport;
        bit               local_hit;
        bit               matched;
        bit               found;
        int               i;
        r = '0;
        r.action = fdu_pkg::ACT_DROP;
        hop = '0;
        eport = '0;
        case (w.cmd)
            fdu_pkg::CMD_WR_ROUTE:
            begin
                if (w.slot < fdu_pkg::ROUTE_SLOTS)
                begin
                    rt_prefix[w.slot] = w.address;
                    rt_mask[w.slot] = w.route_mask;
                    rt_gateway[w.slot] = w.gateway;
                    rt_egress[w.slot] = w.port;
                    rt_valid[w.slot] = w.entry_valid;
                end
                r.action = fdu_pkg::ACT_WRITE_ACK;
            end
            fdu_pkg::CMD_WR_IFACE:
            begin
                if (w.slot < fdu_pkg::PORT_COUNT)
                begin
                    if_addr[w.slot[fdu_pkg::IIDX_W-1:0]] = w.address;
                    if_valid[w.slot[fdu_pkg::IIDX_W-1:0]] = w.entry_valid;
                end
                r.action = fdu_pkg::ACT_WRITE_ACK;
            end
            fdu_pkg::CMD_CLASSIFY:
            begin
                r.out_port = w.port;
                local_hit = 0;
                for (i = 0; i < fdu_pkg::PORT_COUNT; i++)
                    if (if_valid[i] && if_addr[i] == w.address)
                        local_hit = 1;
                if (local_hit)
                begin
                    if (w.protocol == fdu_pkg::PROTO_ICMP)
                    begin
                        if (w.pkt_type == fdu_pkg::ICMP_ECHO_REQUEST && w.pkt_code == 8'd0)
                        begin
                            r.action = fdu_pkg::ACT_ECHO_REPLY;
                            r.new_ttl = fdu_pkg::REPLY_TTL;
                            r.reply_src = w.address;
                            r.reply_type = fdu_pkg::ICMP_ECHO_REPLY;
                        end
                    end
                    else if (w.protocol == fdu_pkg::PROTO_UDP
                             || w.protocol == fdu_pkg::PROTO_TCP)
                    begin
                        r.action = fdu_pkg::ACT_PORT_UNREACH;
                        r.new_ttl = fdu_pkg::REPLY_TTL;
                        r.reply_src = w.address;
                        r.reply_type = fdu_pkg::ICMP_UNREACH;
                        r.reply_code = fdu_pkg::ICMP_CODE_PORT;
                    end
                end
                else if (w.ttl <= 8'd1)
                begin
                    // The arrival interface address is used even when its slot is marked invalid.
                    r.action = fdu_pkg::ACT_TTL_EXCEEDED;
                    r.new_ttl = fdu_pkg::REPLY_TTL;
                    r.reply_src = (w.port < fdu_pkg::PORT_COUNT) ? if_addr[w.port] : 32'd0;
                    r.reply_type = fdu_pkg::ICMP_TIME_EXCEEDED;
                end
                else
                begin
                    // The first matching route ends the search; if its next hop is zero,
                    // the first default entry is taken instead.
                    matched = 0;
                    found = 0;
                    for (i = 0; i < fdu_pkg::ROUTE_SLOTS; i++)
                    begin
                        if (!matched && rt_valid[i] && rt_mask[i] != 0 &&
                            rt_prefix[i] == (w.address & rt_mask[i]))
                        begin
                            matched = 1;
                            hop = (rt_gateway[i] != 0) ? rt_gateway[i] : w.address;
                            eport = rt_egress[i];
                            found = (hop != 0);
                        end
                    end
                    for (i = 0; i < fdu_pkg::ROUTE_SLOTS; i++)
                    begin
                        if (!found && rt_valid[i] && rt_mask[i] == 0 && rt_prefix[i] == 0)
                        begin
                            found = 1;
                            hop = rt_gateway[i];
                            eport = rt_egress[i];
                        end
                    end
                    if (found)
                    begin
                        r.action = fdu_pkg::ACT_FORWARD;
                        r.next_hop = hop;
                        r.out_port = eport;
                        r.new_ttl = w.ttl - 8'd1;
                    end
                    else
                        r.action = fdu_pkg::ACT_NO_ROUTE;
                end
            end
            default:
                r.action = fdu_pkg::ACT_DROP;
        endcase
        return r;
    endfunction

    function automatic word_t noise_word();
        word_t w;
        w.cmd = 2'($urandom);
        w.slot = 4'($urandom);
        w.address = $urandom;
        w.route_mask = $urandom;
        w.gateway = $urandom;
        w.src_addr = $urandom;
        w.port = 2'($urandom);
        w.entry_valid = 1'($urandom);
        w.ttl = 8'($urandom);
        w.protocol = 8'($urandom);
        w.pkt_type = 8'($urandom);
        w.pkt_code = 8'($urandom);
        w.gap = 0;
        w.drain = 0;
        return w;
    endfunction

    function automatic logic [31:0] addr_in_some_route();
        int s;
        s = $urandom_range(0, fdu_pkg::ROUTE_SLOTS - 1);
        if (gen_set[s])
            return gen_prefix[s] | ($urandom & ~gen_mask[s]);
        return $urandom;
    endfunction

    task automatic add_word(input word_t w);
        int r;
        r = $urandom_range(0, 99);
        w.drain = hold_next;
        hold_next = 0;
        if (burst_left > 0)
        begin
            burst_left--;
            w.gap = 0;
        end
        else if (r < 4)
        begin
            burst_left = $urandom_range(10, 30);
            w.gap = 0;
        end
        else if (r < 45)
            w.gap = 0;
        else if (r < 85)
            w.gap = $urandom_range(1, 3);
        else if (r < 97)
            w.gap = $urandom_range(4, 12);
        else
            w.gap = $urandom_range(30, 80);
        words_to_send.push_back(w);
    endtask

    task automatic add_route(input logic [3:0] s, input logic [31:0] prefix,
                             input logic [31:0] mask, input logic [31:0] gw,
                             input logic [1:0] eport, input logic valid);
        word_t w;
        w = noise_word();
        w.cmd = fdu_pkg::CMD_WR_ROUTE;
        w.slot = s;
        w.address = prefix;
        w.route_mask = mask;
        w.gateway = gw;
        w.port = eport;
        w.entry_valid = valid;
        gen_prefix[s] = prefix;
        gen_mask[s] = mask;
        gen_set[s] = 1;
        add_word(w);
    endtask

    task automatic add_iface(input logic [3:0] s, input logic [31:0] addr, input logic valid);
        word_t w;
        w = noise_word();
        w.cmd = fdu_pkg::CMD_WR_IFACE;
        w.slot = s;
        w.address = addr;
        w.entry_valid = valid;
        if (s < fdu_pkg::PORT_COUNT)
            gen_iface[s[fdu_pkg::IIDX_W-1:0]] = addr;
        add_word(w);
    endtask

    task automatic add_packet(input logic [31:0] dst, input logic [1:0] arrival,
                              input logic [7:0] hops_left, input logic [7:0] proto,
                              input logic [7:0] itype, input logic [7:0] icode);
        word_t w;
        w = noise_word();
        w.cmd = fdu_pkg::CMD_CLASSIFY;
        w.address = dst;
        w.port = arrival;
        w.ttl = hops_left;
        w.protocol = proto;
        w.pkt_type = itype;
        w.pkt_code = icode;
        add_word(w);
    endtask

    task automatic add_unused();
        word_t w;
        w = noise_word();
        w.cmd = CMD_UNUSED;
        add_word(w);
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns, result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Driver: a word leaves the queue once its idle gap has passed, and a word marked
    // drain also waits until every outstanding result has come back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
            slot <= '0;
            address <= '0;
            route_mask <= '0;
            gateway <= '0;
            src_addr <= '0;
            port <= '0;
            entry_valid <= 1'b0;
            ttl <= '0;
            protocol <= '0;
            icmp_type_in <= '0;
            icmp_code_in <= '0;
            wait_cnt <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                decisions_due.push_back(decide_forwarding(cur));
                words_sent++;
            end
            if (!start || !busy)
            begin
                if (words_to_send.size() != 0 && wait_cnt >= words_to_send[0].gap &&
                    !(words_to_send[0].drain && decisions_due.size() != 0))
                begin
                    cur = words_to_send.pop_front();
                    start <= 1'b1;
                    cmd <= cur.cmd;
                    slot <= cur.slot;
                    address <= cur.address;
                    route_mask <= cur.route_mask;
                    gateway <= cur.gateway;
                    src_addr <= cur.src_addr;
                    port <= cur.port;
                    entry_valid <= cur.entry_valid;
                    ttl <= cur.ttl;
                    protocol <= cur.protocol;
                    icmp_type_in <= cur.pkt_type;
                    icmp_code_in <= cur.pkt_code;
                    wait_cnt <= 0;
                end
                else
                begin
                    start <= 1'b0;
                    wait_cnt <= wait_cnt + 1;
                end
            end
        end
    end

    // Results are sampled in the middle of the cycle in which done is high.
    always @(negedge clk)
    begin : check_results
        fdu_pkg::result_t want;
        if (rst_n && done)
        begin
            if (decisions_due.size() == 0)
                report_mismatch("result with no word outstanding");
            else
            begin
                want = decisions_due.pop_front();
                action_count[want.action]++;
                check_field("action", 32'(action), 32'(want.action));
                check_field("next_hop", next_hop, want.next_hop);
                check_field("out_port", 32'(out_port), 32'(want.out_port));
                check_field("new_ttl", 32'(new_ttl), 32'(want.new_ttl));
                check_field("reply_src", reply_src, want.reply_src);
                check_field("icmp_type_out", 32'(icmp_type_out), 32'(want.reply_type));
                check_field("icmp_code_out", 32'(icmp_code_out), 32'(want.reply_code));
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall <= 0;
        else
            stall <= stall + 1;
        if (stall >= STALL_LIMIT)
        begin
            $display("no word or result moved for %0d cycles", stall);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int          n;
        int          r;
        int          len;
        logic [31:0] m;
        logic [31:0] p;
        logic [31:0] g;
        logic [31:0] dst;
        logic [7:0]  hops;
        logic [7:0]  proto;

        // An empty table gives no route.
        add_packet(32'h0A000001, 2'd2, 8'd200, fdu_pkg::PROTO_TCP, 8'h00, 8'h00);
        add_iface(4'd0, 32'hC0A80001, 1'b1);
        add_iface(4'd1, 32'h0A0000FE, 1'b1);
        add_iface(4'd2, 32'hAC100001, 1'b0);
        add_iface(4'd3, 32'hFFFFFFFF, 1'b1);
        add_iface(4'd7, 32'h01020304, 1'b1);
        add_route(4'd0, 32'h0A000000, 32'hFF000000, 32'h0, 2'd1, 1'b1);
        add_route(4'd1, 32'h00000000, 32'hFF000000, 32'h0, 2'd2, 1'b1);
        add_route(4'd2, 32'hAC100000, 32'hFFFF0000, 32'h0A000009, 2'd3, 1'b0);
        add_route(4'd15, 32'h0, 32'h0, 32'h0A0000FE, 2'd3, 1'b1);
        // Self delivery wins over an expiring TTL.
        add_packet(32'hC0A80001, 2'd0, 8'd1, fdu_pkg::PROTO_ICMP,
                   fdu_pkg::ICMP_ECHO_REQUEST, 8'd0);
        add_packet(32'hC0A80001, 2'd1, 8'd64, fdu_pkg::PROTO_ICMP,
                   fdu_pkg::ICMP_ECHO_REQUEST, 8'd1);
        add_packet(32'h0A0000FE, 2'd3, 8'd0, fdu_pkg::PROTO_UDP, 8'h00, 8'h00);
        add_packet(32'hFFFFFFFF, 2'd2, 8'd255, fdu_pkg::PROTO_TCP, 8'hFF, 8'hFF);
        add_packet(32'h0A0000FE, 2'd0, 8'd64, 8'hFF, 8'h08, 8'h00);
        add_packet(32'hAC100001, 2'd2, 8'd1, fdu_pkg::PROTO_UDP, 8'h00, 8'h00);
        add_packet(32'h0B000001, 2'd0, 8'd0, fdu_pkg::PROTO_ICMP,
                   fdu_pkg::ICMP_ECHO_REQUEST, 8'd0);
        hold_next = 1;
        add_packet(32'h0A010203, 2'd3, 8'd255, fdu_pkg::PROTO_TCP, 8'h00, 8'h00);
        // A zero destination through a directly attached route falls back to the default.
        add_packet(32'h00000000, 2'd1, 8'd2, fdu_pkg::PROTO_UDP, 8'h00, 8'h00);
        add_packet(32'hAC100505, 2'd0, 8'd64, fdu_pkg::PROTO_ICMP, 8'h00, 8'h00);
        add_packet(32'h00FFFFFF, 2'd1, 8'd100, fdu_pkg::PROTO_TCP, 8'h00, 8'h00);
        add_unused();
        add_route(4'd15, 32'h0, 32'h0, 32'h0A0000FE, 2'd3, 1'b0);
        add_packet(32'h08080808, 2'd1, 8'd64, fdu_pkg::PROTO_UDP, 8'h00, 8'h00);
        add_route(4'd14, 32'h0, 32'h0, 32'h0, 2'd0, 1'b1);
        add_packet(32'h08080808, 2'd2, 8'd64, fdu_pkg::PROTO_UDP, 8'h00, 8'h00);
        add_route(4'd3, 32'h08080808, 32'hFFFFFFFF, 32'h0A000001, 2'd1, 1'b1);
        add_packet(32'h08080808, 2'd3, 8'd3, fdu_pkg::PROTO_ICMP,
                   fdu_pkg::ICMP_ECHO_REQUEST, 8'd0);

        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            r = $urandom_range(0, 99);
            hold_next = ($urandom_range(0, 49) == 0);
            if (r < 14)
            begin
                len = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(1, 32);
                m = (len == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - len));
                p = $urandom & m;
                if ($urandom_range(0, 9) == 0)
                    p = 32'h0;
                else if ($urandom_range(0, 9) == 0)
                    p = $urandom;
                if ($urandom_range(0, 19) == 0)
                    m = $urandom;
                g = ($urandom_range(0, 99) < 35) ? 32'h0 : $urandom;
                add_route(4'($urandom), p, m, g, 2'($urandom), $urandom_range(0, 99) < 80);
            end
            else if (r < 21)
            begin
                p = ($urandom_range(0, 1) == 0) ? $urandom : addr_in_some_route();
                add_iface(($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 3))
                                                       : 4'($urandom_range(4, 15)),
                          p, $urandom_range(0, 99) < 75);
            end
            else if (r < 25)
                add_unused();
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    dst = gen_iface[$urandom_range(0, fdu_pkg::PORT_COUNT - 1)];
                else if (r < 70)
                    dst = addr_in_some_route();
                else if (r < 78)
                    dst = 32'h0;
                else
                    dst = $urandom;
                r = $urandom_range(0, 99);
                if (r < 8)
                    hops = 8'd0;
                else if (r < 16)
                    hops = 8'd1;
                else if (r < 20)
                    hops = 8'd2;
                else if (r < 24)
                    hops = 8'd255;
                else
                    hops = 8'($urandom_range(2, 255));
                r = $urandom_range(0, 99);
                if (r < 35)
                    proto = fdu_pkg::PROTO_ICMP;
                else if (r < 50)
                    proto = fdu_pkg::PROTO_UDP;
                else if (r < 65)
                    proto = fdu_pkg::PROTO_TCP;
                else
                    proto = 8'($urandom);
                add_packet(dst, 2'($urandom), hops, proto,
                           ($urandom_range(0, 99) < 65) ? fdu_pkg::ICMP_ECHO_REQUEST
                                                        : 8'($urandom),
                           ($urandom_range(0, 99) < 70) ? 8'd0 : 8'($urandom));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (words_to_send.size() != 0 || start)
            @(negedge clk);
        while (decisions_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d words sent, %0d results checked, %0d mismatches",
                 words_sent, results_seen, mismatches);
        $display("summary: forward %0d, no route %0d, time exceeded %0d, echo %0d, %s %0d, %s",
                 action_count[fdu_pkg::ACT_FORWARD], action_count[fdu_pkg::ACT_NO_ROUTE],
                 action_count[fdu_pkg::ACT_TTL_EXCEEDED],
                 action_count[fdu_pkg::ACT_ECHO_REPLY],
                 "port unreachable", action_count[fdu_pkg::ACT_PORT_UNREACH],
                 $sformatf("drop %0d, write ack %0d", action_count[fdu_pkg::ACT_DROP],
                           action_count[fdu_pkg::ACT_WRITE_ACK]));
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[ipv4_forward_decision_unit.f]
src/fdu_pkg.sv
src/fdu_route_mem.sv
src/fdu_iface_mem.sv
src/fdu_ctrl.sv
src/ipv4_forward_decision_unit.sv
sim/ipv4_forward_decision_unit_test.sv
